FILE: design/hng_pkg.sv
package hng_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SCALE   = 2'd3;

  localparam logic [10:0] GRID_RESET  = 11'd256;
  localparam logic [15:0] SCALE_RESET = 16'd26;

  localparam int VEC_W = 26;
  localparam int ACC_W = 54;
  localparam int QUO_W = 26;
  localparam int MAG_W = 15;

  localparam logic [8:0]        Y_MULT   = 9'd510;
  localparam logic [MAG_W-1:0]  NORM_ONE = 15'd16384;
  localparam logic [ACC_W-1:0]  VH_BIAS  = 54'd32640;
  localparam logic [ACC_W-1:0]  VH_DIV   = 54'd65280;
  localparam logic [23:0]       VH_MAX   = 24'hFFFFFF;

  typedef struct packed {
    logic [9:0]        col;
    logic [9:0]        row;
    logic signed [10:0] dx;
    logic signed [10:0] dy;
    logic [7:0]        hgt;
    logic              last;
  } job_t;

endpackage

FILE: design/hng_ifs.sv
interface hng_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] height;
  modport source (output valid, height, input ready);
  modport sink   (input valid, height, output ready);
endinterface

interface hng_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         col;
  logic [9:0]         row;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [23:0]        vertex_height;
  logic               last;
  modport source (output valid, col, row, normal_x, normal_y, normal_z, vertex_height, last,
                  input ready);
  modport sink   (input valid, col, row, normal_x, normal_y, normal_z, vertex_height, last,
                  output ready);
endinterface

interface hng_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [hng_pkg::CFG_IDX_W-1:0]    index;
  logic [hng_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/heightmap_normal_generator.sv
// Heightmap normal generator.
// in_chan takes 8-bit height samples in raster order over a grid of
// grid_width x grid_depth points; out_chan returns one result per grid point
// (col, row, Q1.14 unit normal, Q16.8 vertex height, last on the frame's end).
// cfg_chan writes grid_width, grid_depth, height_scale and unit_scale at
// indexes 0..3; it is always ready and must only be used while idle. Writing
// either size restarts the frame.
// Results of row r appear while row r+1 streams in; the last row flushes with
// its own samples, so one sample yields zero to three results.
// A sample with no result passes through transfer, the line-store read and
// write states and dispatch before the next transfer; each result then runs a
// bit-serial normalising shift (a zero vector skips to the vertex height), six
// partial-product squares, a 27-step square root, three 26-step divisions on
// one shared divider and a shift-and-add reciprocal for the vertex height.
// in_chan.ready is high only between samples; an output register holds each
// result, and a stalled receiver holds the sequencer before the next result.
// Reset loads the default registers (256, 256, 26, 26) and starts a new
// frame; the line stores need no clearing.
module heightmap_normal_generator #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  hng_in_if.sink       in_chan,
  hng_out_if.source    out_chan,
  hng_cfg_if.sink      cfg_chan
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_DEPTH);
  localparam int DW = $clog2(MAX_DEPTH + 1);

  localparam int VW = hng_pkg::VEC_W;
  localparam int AW = hng_pkg::ACC_W;
  localparam int QW = hng_pkg::QUO_W;
  localparam int MW = hng_pkg::MAG_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD1    = 4'd1;
  localparam logic [3:0] S_RD2    = 4'd2;
  localparam logic [3:0] S_PICK   = 4'd3;
  localparam logic [3:0] S_LOAD   = 4'd4;
  localparam logic [3:0] S_NORM   = 4'd5;
  localparam logic [3:0] S_SQ     = 4'd6;
  localparam logic [3:0] S_SQRT   = 4'd7;
  localparam logic [3:0] S_DIVSET = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_DSTORE = 4'd10;
  localparam logic [3:0] S_VH1    = 4'd11;
  localparam logic [3:0] S_VH2    = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;
  localparam logic [3:0] S_VH3    = 4'd14;
  localparam logic [3:0] S_VH4    = 4'd15;

  logic [3:0]  state_r;
  logic [10:0] gw_r, gd_r;
  logic [15:0] hs_r, us_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [7:0]  win0_r, win1_r, win2_r;
  logic [7:0]  h_r, mid_r, up2_r;

  hng_pkg::job_t jobs_r [3];
  hng_pkg::job_t cur_r;
  hng_pkg::job_t jobs_nxt [3];
  logic [2:0]  jmask_r, jmask_nxt;

  logic [VW-1:0] ax_r, ay_r, az_r, vor;
  logic          negx_r, negz_r;
  logic [2:0]    step_r;
  logic          hi_r;
  logic [38:0]   prod_r;
  logic [AW-1:0] acc_r, res_r, bit_r, rem_r, dsh_r;
  logic [QW-1:0] quo_r;
  logic [4:0]    dcnt_r;
  logic [1:0]    dsel_r;
  logic [MW-1:0] nx_r, ny_r, nz_r;
  logic [23:0]   mulhs_r;
  logic [39:0]   mulx_r;
  logic [31:0]   vy_r;
  logic [23:0]   vh_r;
  logic [72:0]   vsum;
  logic [32:0]   vq;

  logic               out_valid_r;
  logic [9:0]         out_col_r, out_row_r;
  logic [15:0]        out_nx_r, out_ny_r, out_nz_r;
  logic [23:0]        out_vh_r;
  logic               out_last_r;

  logic [WW-1:0] w_eff;
  logic [DW-1:0] d_eff;

  logic [7:0] store_a [MAX_WIDTH];
  logic [7:0] store_b [MAX_WIDTH];
  logic [7:0] a_q, b_q;
  logic [CW-1:0] a_addr;
  logic          mem_we;

  logic [VW-1:0] sq_op;
  logic [12:0]   sq_part;
  logic [AW-1:0] sq_add, sqrt_t;
  logic [9:0]    absx, absz;
  logic          in_acc;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc         = in_chan.valid && in_chan.ready;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.col           = out_col_r;
  assign out_chan.row           = out_row_r;
  assign out_chan.normal_x      = $signed(out_nx_r);
  assign out_chan.normal_y      = $signed(out_ny_r);
  assign out_chan.normal_z      = $signed(out_nz_r);
  assign out_chan.vertex_height = out_vh_r;
  assign out_chan.last          = out_last_r;

  always_comb begin
    if (gw_r < 11'd2) begin
      w_eff = WW'(2);
    end else if (32'(gw_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(gw_r);
    end
    if (gd_r < 11'd2) begin
      d_eff = DW'(2);
    end else if (32'(gd_r) > MAX_DEPTH) begin
      d_eff = DW'(MAX_DEPTH);
    end else begin
      d_eff = DW'(gd_r);
    end
  end

  assign a_addr = (state_r == S_RD1) ? CW'(col_r + 1'b1) : col_r;
  assign mem_we = (state_r == S_RD2);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_a[col_r] <= h_r;
      store_b[col_r] <= mid_r;
    end
    a_q <= store_a[a_addr];
    b_q <= store_b[col_r];
  end

  always_comb begin
    int ci, ri, wi, di, hi, mi, u2, p0, w1, w2, rv, lft, up, dx, dy;
    ci = 32'(col_r);
    ri = 32'(row_r);
    wi = 32'(w_eff);
    di = 32'(d_eff);
    hi = 32'(h_r);
    mi = 32'(mid_r);
    u2 = 32'(up2_r);
    p0 = 32'(win0_r);
    w1 = 32'(win1_r);
    w2 = 32'(win2_r);
    rv = (ci + 1 < wi) ? 32'(a_q) : mi;

    lft = (ci > 0) ? p0 : mi;
    up  = (ri >= 2) ? u2 : mi;
    dx  = rv - lft;
    dy  = hi - up;
    if (ci == 0 || ci == wi - 1) begin
      dx = dx * 2;
    end
    if (ri == 1) begin
      dy = dy * 2;
    end
    jmask_nxt[0]     = (ri >= 1);
    jobs_nxt[0].col  = 10'(ci);
    jobs_nxt[0].row  = 10'(ri - 1);
    jobs_nxt[0].dx   = 11'(dx);
    jobs_nxt[0].dy   = 11'(dy);
    jobs_nxt[0].hgt  = mid_r;
    jobs_nxt[0].last = 1'b0;

    lft = (ci >= 2) ? w2 : w1;
    dx  = hi - lft;
    if (ci == 1) begin
      dx = dx * 2;
    end
    dy = (w1 - p0) * 2;
    jmask_nxt[1]     = (ri == di - 1) && (ci >= 1);
    jobs_nxt[1].col  = 10'(ci - 1);
    jobs_nxt[1].row  = 10'(ri);
    jobs_nxt[1].dx   = 11'(dx);
    jobs_nxt[1].dy   = 11'(dy);
    jobs_nxt[1].hgt  = win1_r;
    jobs_nxt[1].last = 1'b0;

    jmask_nxt[2]     = (ri == di - 1) && (ci == wi - 1);
    jobs_nxt[2].col  = 10'(ci);
    jobs_nxt[2].row  = 10'(ri);
    jobs_nxt[2].dx   = 11'((hi - w1) * 2);
    jobs_nxt[2].dy   = 11'((hi - mi) * 2);
    jobs_nxt[2].hgt  = h_r;
    jobs_nxt[2].last = 1'b1;
  end

  assign vor  = ax_r | ay_r | az_r;
  assign absx = cur_r.dx[10] ? 10'(-cur_r.dx) : 10'(cur_r.dx);
  assign absz = cur_r.dy[10] ? 10'(-cur_r.dy) : 10'(cur_r.dy);

  // divide by 255 as a multiply by 0x1_0101_0102 and a shift by 40
  assign vsum = 73'({vy_r, 32'b0}) + 73'({vy_r, 24'b0}) + 73'({vy_r, 16'b0}) +
                73'({vy_r, 8'b0}) + 73'({vy_r, 1'b0});
  assign vq   = vsum[72:40];

  always_comb begin
    case (step_r[2:1])
      2'd0:    sq_op = ax_r;
      2'd1:    sq_op = ay_r;
      default: sq_op = az_r;
    endcase
    sq_part = step_r[0] ? sq_op[25:13] : sq_op[12:0];
    sq_add  = hi_r ? AW'({prod_r, 13'b0}) : AW'(prod_r);
    sqrt_t  = res_r + bit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gw_r        <= hng_pkg::GRID_RESET;
      gd_r        <= hng_pkg::GRID_RESET;
      hs_r        <= hng_pkg::SCALE_RESET;
      us_r        <= hng_pkg::SCALE_RESET;
      col_r       <= '0;
      row_r       <= '0;
      win0_r      <= '0;
      win1_r      <= '0;
      win2_r      <= '0;
      jmask_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          hng_pkg::CFG_GRID_WIDTH: begin
            gw_r  <= cfg_chan.data[10:0];
            col_r <= '0;
            row_r <= '0;
          end
          hng_pkg::CFG_GRID_DEPTH: begin
            gd_r  <= cfg_chan.data[10:0];
            col_r <= '0;
            row_r <= '0;
          end
          hng_pkg::CFG_HEIGHT_SCALE: hs_r <= cfg_chan.data;
          hng_pkg::CFG_UNIT_SCALE:   us_r <= cfg_chan.data;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            h_r     <= in_chan.height;
            state_r <= S_RD1;
          end
        end
        S_RD1: begin
          mid_r   <= a_q;
          up2_r   <= b_q;
          state_r <= S_RD2;
        end
        S_RD2: begin
          jobs_r  <= jobs_nxt;
          jmask_r <= jmask_nxt;
          win0_r  <= mid_r;
          win1_r  <= h_r;
          win2_r  <= win1_r;
          if (WW'(col_r) + 1'b1 >= w_eff) begin
            col_r <= '0;
            if (DW'(row_r) + 1'b1 >= d_eff) begin
              row_r <= '0;
            end else begin
              row_r <= RW'(row_r + 1'b1);
            end
          end else begin
            col_r <= CW'(col_r + 1'b1);
          end
          state_r <= S_PICK;
        end
        S_PICK: begin
          if (jmask_r[0]) begin
            cur_r      <= jobs_r[0];
            jmask_r[0] <= 1'b0;
            state_r    <= S_LOAD;
          end else if (jmask_r[1]) begin
            cur_r      <= jobs_r[1];
            jmask_r[1] <= 1'b0;
            state_r    <= S_LOAD;
          end else if (jmask_r[2]) begin
            cur_r      <= jobs_r[2];
            jmask_r[2] <= 1'b0;
            state_r    <= S_LOAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_LOAD: begin
          ax_r    <= VW'(absx * hs_r);
          ay_r    <= VW'(hng_pkg::Y_MULT * us_r);
          az_r    <= VW'(absz * hs_r);
          negx_r  <= (cur_r.dx > 11'sd0);
          negz_r  <= (cur_r.dy > 11'sd0);
          state_r <= S_NORM;
        end
        S_NORM: begin
          if (vor == '0) begin
            nx_r    <= '0;
            ny_r    <= hng_pkg::NORM_ONE;
            nz_r    <= '0;
            state_r <= S_VH1;
          end else if (!vor[VW-1]) begin
            ax_r <= {ax_r[VW-2:0], 1'b0};
            ay_r <= {ay_r[VW-2:0], 1'b0};
            az_r <= {az_r[VW-2:0], 1'b0};
          end else begin
            step_r  <= '0;
            acc_r   <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          prod_r <= sq_op * sq_part;
          hi_r   <= step_r[0];
          if (step_r != 3'd0) begin
            acc_r <= acc_r + sq_add;
          end
          step_r <= step_r + 3'd1;
          if (step_r == 3'd6) begin
            res_r   <= '0;
            bit_r   <= AW'(1) << 52;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (acc_r >= sqrt_t) begin
            acc_r <= acc_r - sqrt_t;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == AW'(1)) begin
            dsel_r  <= 2'd0;
            state_r <= S_DIVSET;
          end
        end
        S_DIVSET: begin
          case (dsel_r)
            2'd0:    rem_r <= AW'({ax_r, 15'b0}) + AW'(res_r[26:0]);
            2'd1:    rem_r <= AW'({ay_r, 15'b0}) + AW'(res_r[26:0]);
            default: rem_r <= AW'({az_r, 15'b0}) + AW'(res_r[26:0]);
          endcase
          dsh_r   <= AW'({res_r[26:0], 1'b0}) << 25;
          quo_r   <= '0;
          dcnt_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (rem_r >= dsh_r) begin
            rem_r <= rem_r - dsh_r;
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          dsh_r  <= dsh_r >> 1;
          dcnt_r <= dcnt_r + 5'd1;
          if (dcnt_r == 5'(QW - 1)) begin
            state_r <= S_DSTORE;
          end
        end
        S_DSTORE: begin
          case (dsel_r)
            2'd0: nx_r <= (quo_r > QW'(hng_pkg::NORM_ONE)) ? hng_pkg::NORM_ONE : MW'(quo_r);
            2'd1: ny_r <= (quo_r > QW'(hng_pkg::NORM_ONE)) ? hng_pkg::NORM_ONE : MW'(quo_r);
            default: nz_r <= (quo_r > QW'(hng_pkg::NORM_ONE)) ? hng_pkg::NORM_ONE : MW'(quo_r);
          endcase
          if (dsel_r == 2'd2) begin
            state_r <= S_VH1;
          end else begin
            dsel_r  <= dsel_r + 2'd1;
            state_r <= S_DIVSET;
          end
        end
        S_VH1: begin
          mulhs_r <= cur_r.hgt * hs_r;
          state_r <= S_VH2;
        end
        S_VH2: begin
          mulx_r  <= mulhs_r * us_r;
          state_r <= S_VH3;
        end
        S_VH3: begin
          vy_r    <= 32'((AW'(mulx_r) + hng_pkg::VH_BIAS) >> 8);
          state_r <= S_VH4;
        end
        S_VH4: begin
          vh_r    <= (vq > 33'(hng_pkg::VH_MAX)) ? hng_pkg::VH_MAX : vq[23:0];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_col_r   <= cur_r.col;
            out_row_r   <= cur_r.row;
            out_nx_r    <= negx_r ? (16'd0 - 16'(nx_r)) : 16'(nx_r);
            out_ny_r    <= 16'(ny_r);
            out_nz_r    <= negz_r ? (16'd0 - 16'(nz_r)) : 16'(nz_r);
            out_vh_r    <= vh_r;
            out_last_r  <= cur_r.last;
            state_r     <= S_PICK;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
